// ===== design/tcss_pkg.sv =====
// Shared types, constants and helpers for the tick counter seven-segment scan block.
// No dependencies; imported by tcss_div, tick_counter_seven_segment_scan and the bench.
package tcss_pkg;

    // Item and field widths
    localparam int ACT_W   = 2;
    localparam int KEY_W   = 4;
    localparam int CNT_W   = 16;
    localparam int PER_W   = 4;
    localparam int SHOW_W  = 10;
    localparam int SEG_W   = 8;
    localparam int DIGIT_COUNT = 4;
    localparam int POS_W   = $clog2(DIGIT_COUNT);
    localparam int STEP_W  = $clog2(CNT_W);
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 32;

    // Action codes (tuser)
    localparam logic [ACT_W-1:0] ACT_TICK = 2'd0;
    localparam logic [ACT_W-1:0] ACT_KEY  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SCAN = 2'd2;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_UP    = 4'd3;
    localparam logic [KEY_W-1:0] KEY_RESET = 4'd6;
    localparam logic [KEY_W-1:0] KEY_DOWN  = 4'd9;

    // Limits and fixed values
    localparam logic [PER_W-1:0]  PERIOD_MAX     = 4'd15;
    localparam logic [PER_W-1:0]  PERIOD_MIN     = 4'd1;
    localparam logic [PER_W-1:0]  PERIOD_DEFAULT = 4'd5;
    localparam logic [PER_W-1:0]  DEC_BASE       = 4'd10;
    localparam logic [CNT_W-1:0]  SHOW_LIMIT     = 16'd1000;
    localparam logic [SEG_W-1:0]  SEG_BLANK      = 8'hFF;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_RESULT
    } t_state;

    // Divider request and status
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] dividend;
        logic [PER_W-1:0] divisor;
    } t_div_ctrl;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [CNT_W-1:0] quotient;
        logic [PER_W-1:0] remainder;
    } t_div_stat;

    // Active-low segment pattern of one decimal digit
    function automatic logic [SEG_W-1:0] seg_of(input logic [PER_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ===== design/tcss_div.sv =====
// Shared restoring divider: 16-bit dividend by 4-bit divisor, one quotient bit a cycle.
// Depends on tcss_pkg for widths and the request/status structs.
module tcss_div
    import tcss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_ctrl i_ctrl,
    output t_div_stat o_stat
);

    logic             r_busy;
    logic             r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0] r_quo;
    logic [PER_W-1:0] r_rem;
    logic [PER_W-1:0] r_dsr;

    logic [PER_W:0]   w_trial;
    logic [PER_W:0]   w_diff;
    logic             w_ge;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        w_trial = {r_rem, r_quo[CNT_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        w_ge    = (w_trial >= {1'b0, r_dsr});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(CNT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start && !r_busy) begin
            r_quo <= i_ctrl.dividend;
            r_rem <= '0;
            r_dsr <= i_ctrl.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[CNT_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[PER_W-1:0] : w_trial[PER_W-1:0];
        end
    end

    assign o_stat.busy      = r_busy;
    assign o_stat.done      = r_done;
    assign o_stat.quotient  = r_quo;
    assign o_stat.remainder = r_rem;

    // Checks
    a_rem_below_dsr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_dsr))
        else $error("divider remainder not below divisor");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding run");

endmodule

// ===== design/tick_counter_seven_segment_scan.sv =====
// Tick counter with four-digit seven-segment scan output; uses tcss_pkg and tcss_div.
// Path from the accepting edge to o_m_tvalid: a key press or spare action goes straight to the
// result state; a tick runs one 16-step divider run (launch, wait); a scan step for digit
// position p (0..3) repeats the run, dividing by ten, for each position from 0 up to p.
// One transaction at a time: the next is taken on return to idle, which waits while the result side stalls.
// Reset (synchronous, active low): counters and scan position 0, period 5, output empty.
module tick_counter_seven_segment_scan
    import tcss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [3:0] key_code, rest zero
    input  logic [ACT_W-1:0]      i_s_tuser,   // [1:0] action
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata    // [3:0] digit_select, [11:4] segments,
                                               // [15:12] period_now, [25:16] shown_value
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]       r_tick;
    logic [PER_W-1:0]       r_period;
    logic [CNT_W-1:0]       r_shown;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       r_pass;
    logic                   r_is_scan;
    logic [CNT_W-1:0]       r_dvd;
    logic [PER_W-1:0]       r_dsr;
    logic [DIGIT_COUNT-1:0] r_sel;
    logic [SEG_W-1:0]       r_seg;

    logic                   r_m_valid;
    logic [OUT_DATA_W-1:0]  r_m_data;

    t_div_ctrl              w_div_ctrl;
    t_div_stat              w_div_stat;
    logic                   w_in_acc;
    logic                   w_out_free;
    logic [CNT_W-1:0]       w_tick_inc;
    logic [SHOW_W-1:0]      w_clamped;
    logic [ACT_W-1:0]       w_act;
    logic [KEY_W-1:0]       w_key;

    assign w_act      = i_s_tuser;
    assign w_key      = i_s_tdata[KEY_W-1:0];
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_m_valid || i_m_tready;
    assign w_tick_inc = r_tick + 1'b1;
    assign w_clamped  = (r_shown > SHOW_LIMIT) ? SHOW_LIMIT[SHOW_W-1:0] : r_shown[SHOW_W-1:0];

    // Shared divider
    tcss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_div_ctrl),
        .o_stat  (w_div_stat)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control outputs
    always_comb begin
        n_state             = r_state;
        o_s_tready          = 1'b0;
        w_div_ctrl.start    = 1'b0;
        w_div_ctrl.dividend = r_dvd;
        w_div_ctrl.divisor  = r_dsr;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (w_act == ACT_TICK || w_act == ACT_SCAN) begin
                        n_state = ST_LAUNCH;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_LAUNCH: begin
                w_div_ctrl.start = 1'b1;
                n_state          = ST_WAIT;
            end
            ST_WAIT: begin
                if (w_div_stat.done) begin
                    if (r_is_scan && r_pass != r_pos) begin
                        n_state = ST_LAUNCH;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_period  <= PERIOD_DEFAULT;
            r_shown   <= '0;
            r_pos     <= '0;
            r_is_scan <= 1'b0;
        end else begin
            // accept: tick increment, key handling, item kind
            if (w_in_acc) begin
                r_is_scan <= (w_act == ACT_SCAN);
                if (w_act == ACT_TICK) begin
                    r_tick <= w_tick_inc;
                end else if (w_act == ACT_KEY) begin
                    priority if (w_key == KEY_UP && r_period < PERIOD_MAX) begin
                        r_period <= r_period + 1'b1;
                    end else if (w_key == KEY_RESET) begin
                        r_period <= PERIOD_DEFAULT;
                    end else if (w_key == KEY_DOWN && r_period > PERIOD_MIN) begin
                        r_period <= r_period - 1'b1;
                    end else begin
                        // other codes, or a limit already reached: period unchanged
                        r_period <= r_period;
                    end
                end
            end
            // tick divisible by period: advance the shown count
            if (r_state == ST_WAIT && w_div_stat.done && !r_is_scan
                && w_div_stat.remainder == '0) begin
                r_shown <= r_shown + 1'b1;
            end
            // scan result loaded into the output register: next digit position
            if (r_state == ST_RESULT && w_out_free && r_is_scan) begin
                r_pos <= (r_pos == POS_W'(DIGIT_COUNT - 1)) ? '0 : r_pos + 1'b1;
            end
        end
    end

    // Divider operands and result fields
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pass <= '0;
            r_sel  <= '0;
            r_seg  <= SEG_BLANK;
            if (w_act == ACT_TICK) begin
                r_dvd <= w_tick_inc;
                r_dsr <= r_period;
            end else begin
                r_dvd <= CNT_W'(w_clamped);
                r_dsr <= DEC_BASE;
            end
            if (w_act == ACT_SCAN) begin
                r_sel <= DIGIT_COUNT'(1) << r_pos;
            end
        end else if (r_state == ST_WAIT && w_div_stat.done && r_is_scan) begin
            if (r_pass == r_pos) begin
                r_seg <= seg_of(w_div_stat.remainder);
            end else begin
                r_dvd  <= w_div_stat.quotient;
                r_pass <= r_pass + 1'b1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == ST_RESULT && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESULT && w_out_free) begin
            r_m_data <= {6'b0, w_clamped, r_period, r_seg, r_sel};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // Checks
    a_period_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_period != '0)
        else $error("period reached zero");

    a_div_only_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> (r_state == ST_WAIT))
        else $error("divider finished outside the wait state");

    a_launch_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_ctrl.start |-> !w_div_stat.busy)
        else $error("divider launched while busy");

    a_shown_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> (r_m_data[25:16] <= SHOW_LIMIT[SHOW_W-1:0]))
        else $error("shown value above limit");

endmodule

// ===== bench/tick_counter_seven_segment_scan_tb.sv =====
// Self-checking bench for the tick counter seven-segment scan block.
// Depends on tcss_pkg and the block; each result is checked against a predictor or directed row.
module tick_counter_seven_segment_scan_tb
    import tcss_pkg::*;
();

    // Action code the block leaves unused
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 215;

    // One display readout, as carried in the result tdata
    typedef struct packed {
        logic [3:0]        sel;
        logic [SEG_W-1:0]  seg;
        logic [PER_W-1:0]  per;
        logic [SHOW_W-1:0] shown;
    } t_readout;

    // One row of the directed stimulus; want only applies when typed is set
    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic [KEY_W-1:0] key;
        logic             typed;
        t_readout         want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;   // [3:0] key_code, rest zero
    logic [ACT_W-1:0]      i_s_tuser = '0;   // [1:0] action
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;        // [3:0] select, [11:4] segments,
                                             // [15:12] period, [25:16] shown value

    // Predictor state
    logic [CNT_W-1:0]  tick_cnt;
    logic [CNT_W-1:0]  shown_cnt;
    logic [PER_W-1:0]  period_val;
    logic [POS_W-1:0]  scan_pos;
    logic [SEG_W-1:0]  digit_segs [0:9] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                            8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};

    t_readout  pending_readouts [$];
    t_stim_row dir_rows [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int fail_count     = 0;
    int results_seen   = 0;
    int items_sent     = 0;
    int cycle_count    = 0;
    int tick_wraps     = 0;
    int scans_clamped  = 0;

    tick_counter_seven_segment_scan i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Advance the predicted display state by one item and return its readout
    function automatic t_readout step_display(input logic [ACT_W-1:0] act,
                                              input logic [KEY_W-1:0] key);
        t_readout          r;
        logic [SHOW_W-1:0] v;
        logic [3:0]        d;
        r.sel = '0;
        r.seg = SEG_BLANK;
        v = (shown_cnt > SHOW_LIMIT) ? SHOW_LIMIT[SHOW_W-1:0] : shown_cnt[SHOW_W-1:0];
        case (act)
            ACT_TICK: begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt == '0)
                    tick_wraps++;
                if (tick_cnt % period_val == '0)
                    shown_cnt = shown_cnt + 1'b1;
            end
            ACT_KEY: begin
                if (key == KEY_UP && period_val < PERIOD_MAX)
                    period_val = period_val + 1'b1;
                else if (key == KEY_RESET)
                    period_val = PERIOD_DEFAULT;
                else if (key == KEY_DOWN && period_val > PERIOD_MIN)
                    period_val = period_val - 1'b1;
            end
            ACT_SCAN: begin
                case (scan_pos)
                    2'd0:    d = 4'(v % 10);
                    2'd1:    d = 4'((v / 10) % 10);
                    2'd2:    d = 4'((v / 100) % 10);
                    default: d = 4'((v / 1000) % 10);
                endcase
                if (shown_cnt > SHOW_LIMIT)
                    scans_clamped++;
                r.sel = 4'b0001 << scan_pos;
                r.seg = digit_segs[d];
                scan_pos = scan_pos + 1'b1;
            end
            default: ;
        endcase
        r.per = period_val;
        r.shown = (shown_cnt > SHOW_LIMIT) ? SHOW_LIMIT[SHOW_W-1:0] : shown_cnt[SHOW_W-1:0];
        return r;
    endfunction

    function automatic void add_row(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                                    input logic typed, input t_readout want);
        t_stim_row row;
        row.act = act;
        row.key = key;
        row.typed = typed;
        row.want = want;
        dir_rows.push_back(row);
    endfunction

    // Offer one item, wait for the transaction, then log what should come back
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                             input logic typed, input t_readout want);
        t_readout predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= act;
        i_s_tdata <= {{(IN_DATA_W-KEY_W){1'b0}}, key};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        predicted = step_display(act, key);
        pending_readouts.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Result side ready: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every result transaction with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_readout got;
        t_readout want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.sel   = o_m_tdata[3:0];
            got.seg   = o_m_tdata[11:4];
            got.per   = o_m_tdata[15:12];
            got.shown = o_m_tdata[25:16];
            results_seen++;
            if (pending_readouts.size() == 0) begin
                $error("result with nothing expected: tdata %h", o_m_tdata);
                fail_count++;
            end else begin
                want = pending_readouts.pop_front();
                if (got.sel !== want.sel) begin
                    $error("digit_select: expected %h, got %h", want.sel, got.sel);
                    fail_count++;
                end
                if (got.seg !== want.seg) begin
                    $error("segments: expected %h, got %h", want.seg, got.seg);
                    fail_count++;
                end
                if (got.per !== want.per) begin
                    $error("period_now: expected %0d, got %0d", want.per, got.per);
                    fail_count++;
                end
                if (got.shown !== want.shown) begin
                    $error("shown_value: expected %0d, got %0d", want.shown, got.shown);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int       phase_items;
        int       pick;
        int       len;
        t_readout none;
        none = '0;
        tick_cnt = '0;
        shown_cnt = '0;
        period_val = PERIOD_DEFAULT;
        scan_pos = '0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full scan after reset, spare action, every key, period floor, ticks and a rescan
        add_row(ACT_SCAN,  4'd0,      1'b1, {4'b0001, 8'hC0, 4'd5, 10'd0});
        add_row(ACT_SCAN,  4'd0,      1'b1, {4'b0010, 8'hC0, 4'd5, 10'd0});
        add_row(ACT_SCAN,  4'd0,      1'b1, {4'b0100, 8'hC0, 4'd5, 10'd0});
        add_row(ACT_SCAN,  4'd0,      1'b1, {4'b1000, 8'hC0, 4'd5, 10'd0});
        add_row(ACT_SPARE, 4'd15,     1'b1, {4'b0000, SEG_BLANK, 4'd5, 10'd0});
        add_row(ACT_KEY,   KEY_RESET, 1'b1, {4'b0000, SEG_BLANK, 4'd5, 10'd0});
        add_row(ACT_KEY,   KEY_UP,    1'b1, {4'b0000, SEG_BLANK, 4'd6, 10'd0});
        add_row(ACT_KEY,   KEY_DOWN,  1'b1, {4'b0000, SEG_BLANK, 4'd5, 10'd0});
        add_row(ACT_KEY,   4'd0,      1'b1, {4'b0000, SEG_BLANK, 4'd5, 10'd0});
        add_row(ACT_KEY,   4'd15,     1'b1, {4'b0000, SEG_BLANK, 4'd5, 10'd0});
        add_row(ACT_KEY,   KEY_DOWN,  1'b1, {4'b0000, SEG_BLANK, 4'd4, 10'd0});
        add_row(ACT_KEY,   KEY_DOWN,  1'b1, {4'b0000, SEG_BLANK, 4'd3, 10'd0});
        add_row(ACT_KEY,   KEY_DOWN,  1'b1, {4'b0000, SEG_BLANK, 4'd2, 10'd0});
        add_row(ACT_KEY,   KEY_DOWN,  1'b1, {4'b0000, SEG_BLANK, 4'd1, 10'd0});
        add_row(ACT_KEY,   KEY_DOWN,  1'b1, {4'b0000, SEG_BLANK, 4'd1, 10'd0});
        add_row(ACT_TICK,  4'd0,      1'b1, {4'b0000, SEG_BLANK, 4'd1, 10'd1});
        add_row(ACT_TICK,  4'd10,     1'b1, {4'b0000, SEG_BLANK, 4'd1, 10'd2});
        add_row(ACT_SCAN,  4'd0,      1'b1, {4'b0001, 8'hA4, 4'd1, 10'd2});
        add_row(ACT_SCAN,  4'd5,      1'b1, {4'b0010, 8'hC0, 4'd1, 10'd2});
        add_row(ACT_KEY,   KEY_RESET, 1'b1, {4'b0000, SEG_BLANK, 4'd5, 10'd2});
        add_row(ACT_TICK,  4'd0,      1'b0, none);
        add_row(ACT_TICK,  4'd0,      1'b0, none);
        add_row(ACT_TICK,  4'd0,      1'b0, none);
        add_row(ACT_SPARE, 4'd0,      1'b0, none);
        add_row(ACT_KEY,   KEY_UP,    1'b0, none);
        foreach (dir_rows[i])
            send_item(dir_rows[i].act, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);

        // Walk the period down to its floor so the count moves quickly at first
        repeat (15) send_item(ACT_KEY, KEY_DOWN, 1'b0, none);

        // Random part in four idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            // long hold-off on the result side so the input backs up
            if (ph == 0)
                hold_left <= HOLD_CYCLES;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    len = $urandom_range(1, 8);
                    repeat (len) send_item(ACT_TICK, 4'($urandom_range(15)), 1'b0, none);
                end else if (pick < 60) begin
                    len = $urandom_range(1, 4);
                    repeat (len) send_item(ACT_SCAN, 4'($urandom_range(15)), 1'b0, none);
                end else if (pick < 92) begin
                    case ($urandom_range(3))
                        0: begin
                            len = $urandom_range(1, 16);
                            repeat (len) send_item(ACT_KEY, KEY_UP, 1'b0, none);
                        end
                        1: begin
                            len = $urandom_range(1, 16);
                            repeat (len) send_item(ACT_KEY, KEY_DOWN, 1'b0, none);
                        end
                        2: begin
                            len = 1;
                            send_item(ACT_KEY, KEY_RESET, 1'b0, none);
                        end
                        default: begin
                            len = 1;
                            send_item(ACT_KEY, 4'($urandom_range(15)), 1'b0, none);
                        end
                    endcase
                end else begin
                    len = 1;
                    send_item(ACT_SPARE, 4'($urandom_range(15)), 1'b0, none);
                end
                phase_items += len;
            end
        end
        i_s_tvalid <= 1'b0;

        // Drain, then allow for anything stray
        while (pending_readouts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transactions in, %0d results checked, %0d failures",
                 items_sent, results_seen, fail_count);
        $display("tick counter wrapped %0d time(s), %0d scans showed a clamped count",
                 tick_wraps, scans_clamped);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== tick_counter_seven_segment_scan.f =====
design/tcss_pkg.sv
design/tcss_div.sv
design/tick_counter_seven_segment_scan.sv
bench/tick_counter_seven_segment_scan_tb.sv
